// ----- src/tcw_pkg.sv -----
// Text console writer package: field widths, character codes, opcodes and
// default geometry. No dependencies; used by the interfaces and text_console_writer_top.
package tcw_pkg;

  localparam int NumColumnsDef = 80;
  localparam int NumRowsDef    = 25;

  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_IDX_W = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = ATTR_W + CHAR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT_CHAR = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_READ     = 2'd2
  } opcode_e;

  typedef logic [CELL_W-1:0] cell_t;

endpackage

// ----- src/tcw_in_if.sv -----
// Request channel of the text console writer: valid/ready plus payload.
// Depends on tcw_pkg for field widths.
interface tcw_in_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::OPCODE_W-1:0]    opcode;
  logic [tcw_pkg::CHAR_W-1:0]      char_code;
  logic [tcw_pkg::CELL_IDX_W-1:0]  cell_index;

  modport source (output valid, opcode, char_code, cell_index, input ready);
  modport sink   (input valid, opcode, char_code, cell_index, output ready);
endinterface

// ----- src/tcw_out_if.sv -----
// Result channel of the text console writer: valid/ready plus payload.
// Depends on tcw_pkg for field widths.
interface tcw_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row_out;
  logic [tcw_pkg::COL_OUT_W-1:0]  cursor_col_out;
  logic [tcw_pkg::CHAR_W-1:0]     read_char;
  logic [tcw_pkg::ATTR_W-1:0]     read_attr;

  modport source (output valid, cursor_row_out, cursor_col_out, read_char, read_attr,
                  input ready);
  modport sink   (input valid, cursor_row_out, cursor_col_out, read_char, read_attr,
                  output ready);
endinterface

// ----- src/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/text_console_writer_top.sv -----
// Text console writer: frame store in one RAM, cursor and sweep sequencer.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if and tcw_ram.
//
// Sequence after accept: put char goes through EXEC, read cell through EXEC
// and READ, clear screen through EXEC, FILL and FINISH, and a scrolling put
// char through EXEC, COPY, DRAIN, FILL and FINISH. One request is in work at
// a time: a new one is taken only back in IDLE, and scroll and clear walk the
// store through the single RAM. Reset: cursor goes to 0,0 and attribute to
// 0x0F; then a clearing pass fills the store with blanks, during which no
// request is accepted (configuration writes are still taken).
module text_console_writer_top #(
  parameter int NUM_COLUMNS = tcw_pkg::NumColumnsDef,
  parameter int NUM_ROWS    = tcw_pkg::NumRowsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata_i,
  tcw_in_if.sink                     in_i,
  tcw_out_if.source                  out_o
);

  localparam int NumCells     = NUM_COLUMNS * NUM_ROWS;
  localparam int AddrW        = $clog2(NumCells);
  localparam int CurW         = $clog2(NumCells + 1);
  localparam int ColW         = $clog2(NUM_COLUMNS + 1);
  localparam int RowW         = $clog2(NUM_ROWS);
  localparam int LastRowStart = (NUM_ROWS - 1) * NUM_COLUMNS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]                    state_q, state_d;
  logic [tcw_pkg::ATTR_W-1:0]    attr_q;
  logic [RowW-1:0]               row_q, row_d;
  logic [ColW-1:0]               col_q, col_d;
  // Linear address of the cursor, kept equal to row*NUM_COLUMNS+col
  logic [CurW-1:0]               addr_q, addr_d;
  logic [AddrW-1:0]              ptr_q, ptr_d;
  logic                          cp_valid_q, cp_valid_d;
  logic [AddrW-1:0]              cp_waddr_q, cp_waddr_d;
  tcw_pkg::cell_t                fill_word_q, fill_word_d;
  logic                          pend_q, pend_d;
  logic                          report_q, report_d;

  // Request payload
  logic [tcw_pkg::OPCODE_W-1:0]   op_q;
  logic [tcw_pkg::CHAR_W-1:0]     ch_q;
  logic [tcw_pkg::CELL_IDX_W-1:0] cell_q;

  // Result register
  logic                           out_valid_q, out_valid_d;
  logic                           out_load;
  logic [tcw_pkg::CHAR_W-1:0]     out_rc;
  logic [tcw_pkg::ATTR_W-1:0]     out_ra;
  logic [tcw_pkg::ROW_OUT_W-1:0]  row_out_q;
  logic [tcw_pkg::COL_OUT_W-1:0]  col_out_q;
  logic [tcw_pkg::CHAR_W-1:0]     rc_q;
  logic [tcw_pkg::ATTR_W-1:0]     ra_q;
  logic                           out_free;

  // RAM port
  logic                           ram_we;
  logic [AddrW-1:0]               ram_waddr;
  tcw_pkg::cell_t                 ram_wdata;
  logic [AddrW-1:0]               ram_raddr;
  tcw_pkg::cell_t                 ram_rdata;

  logic                           cell_in_range;
  logic [AddrW-1:0]               cell_addr;
  logic [31:0]                    row_ext;
  logic [31:0]                    col_ext;
  logic                           in_accept;
  logic                           last_row;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (NumCells)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready    = (state_q == ST_IDLE);
  assign in_accept     = in_i.valid && in_i.ready;
  // The output slot can take a new result when empty or draining this cycle
  assign out_free      = !out_valid_q || out_o.ready;
  assign cell_in_range = 32'(cell_q) < 32'(NumCells);
  assign cell_addr     = AddrW'(cell_q);
  assign last_row      = !(row_q < RowW'(NUM_ROWS - 1));

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    addr_d      = addr_q;
    ptr_d       = ptr_q;
    cp_valid_d  = 1'b0;
    cp_waddr_d  = cp_waddr_q;
    fill_word_d = fill_word_q;
    pend_d      = pend_q;
    report_d    = report_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q[AddrW-1:0];
    ram_wdata   = {attr_q, ch_q};
    ram_raddr   = cell_addr;
    out_load    = 1'b0;
    out_rc      = '0;
    out_ra      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (op_q)
          tcw_pkg::OP_PUT_CHAR: begin
            if (ch_q == tcw_pkg::NEWLINE_CODE || col_q == ColW'(NUM_COLUMNS)) begin
              if (last_row) begin
                // Scroll: copy rows up, blank the last row, then finish
                col_d      = '0;
                addr_d     = CurW'(LastRowStart);
                pend_d     = (ch_q != tcw_pkg::NEWLINE_CODE);
                report_d   = 1'b1;
                ptr_d      = AddrW'(NUM_COLUMNS);
                state_d    = ST_COPY;
              end else if (out_free) begin
                row_d = row_q + 1'b1;
                if (ch_q == tcw_pkg::NEWLINE_CODE) begin
                  col_d  = '0;
                  addr_d = CurW'(addr_q + CurW'(NUM_COLUMNS) - CurW'(col_q));
                end else begin
                  // A full row leaves addr at the start of the next row
                  ram_we = 1'b1;
                  col_d  = ColW'(1);
                  addr_d = addr_q + 1'b1;
                end
                out_load = 1'b1;
                state_d  = ST_IDLE;
              end
            end else if (out_free) begin
              ram_we   = 1'b1;
              col_d    = col_q + 1'b1;
              addr_d   = addr_q + 1'b1;
              out_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end
          tcw_pkg::OP_CLEAR: begin
            ptr_d       = '0;
            fill_word_d = {attr_q, tcw_pkg::SPACE_CODE};
            pend_d      = 1'b0;
            report_d    = 1'b1;
            state_d     = ST_FILL;
          end
          tcw_pkg::OP_READ: begin
            if (cell_in_range) begin
              state_d = ST_READ;
            end else if (out_free) begin
              out_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end
        endcase
      end

      ST_READ: begin
        // Hold the read address so the data stays while the output stalls
        if (out_free) begin
          out_load = 1'b1;
          out_rc   = ram_rdata[tcw_pkg::CHAR_W-1:0];
          out_ra   = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          state_d  = ST_IDLE;
        end
      end

      ST_COPY: begin
        // Read one cell a cycle, write it one row up in the cycle after
        ram_raddr  = ptr_q;
        ram_we     = cp_valid_q;
        ram_waddr  = cp_waddr_q;
        ram_wdata  = ram_rdata;
        cp_valid_d = 1'b1;
        cp_waddr_d = ptr_q - AddrW'(NUM_COLUMNS);
        ptr_d      = ptr_q + 1'b1;
        if (ptr_q == AddrW'(NumCells - 1)) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        ram_we      = cp_valid_q;
        ram_waddr   = cp_waddr_q;
        ram_wdata   = ram_rdata;
        ptr_d       = AddrW'(LastRowStart);
        fill_word_d = {attr_q, tcw_pkg::SPACE_CODE};
        state_d     = ST_FILL;
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = fill_word_q;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == AddrW'(NumCells - 1)) begin
          state_d = report_q ? ST_FINISH : ST_IDLE;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          if (pend_q) begin
            ram_we = 1'b1;
            col_d  = col_q + 1'b1;
            addr_d = addr_q + 1'b1;
          end
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign row_ext = 32'(row_d);
  assign col_ext = 32'(col_d);

  // Control state; reset starts the clearing pass with the reset blank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      attr_q      <= tcw_pkg::ATTR_RESET;
      row_q       <= '0;
      col_q       <= '0;
      addr_q      <= '0;
      ptr_q       <= '0;
      cp_valid_q  <= 1'b0;
      fill_word_q <= {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CODE};
      pend_q      <= 1'b0;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      row_q       <= row_d;
      col_q       <= col_d;
      addr_q      <= addr_d;
      ptr_q       <= ptr_d;
      cp_valid_q  <= cp_valid_d;
      fill_word_q <= fill_word_d;
      pend_q      <= pend_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cp_waddr_q <= cp_waddr_d;
    if (in_accept) begin
      op_q   <= in_i.opcode;
      ch_q   <= in_i.char_code;
      cell_q <= in_i.cell_index;
    end
    if (out_load) begin
      row_out_q <= row_ext[tcw_pkg::ROW_OUT_W-1:0];
      col_out_q <= col_ext[tcw_pkg::COL_OUT_W-1:0];
      rc_q      <= out_rc;
      ra_q      <= out_ra;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cursor_row_out = row_out_q;
  assign out_o.cursor_col_out = col_out_q;
  assign out_o.read_char      = rc_q;
  assign out_o.read_attr      = ra_q;

  // The cursor never runs past the full-row position
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) <= 32'(NUM_COLUMNS))
    else $error("cursor column beyond row width");

  // The tracked linear address matches the cursor position
  a_addr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(addr_q) == 32'(row_q) * 32'(NUM_COLUMNS) + 32'(col_q))
    else $error("cursor address out of step with row and column");

  // The store is never written while idle or while a read is pending
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE && state_q != ST_READ))
    else $error("frame store written outside a request");

  // A new result appears only from a finishing state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_READ ||
                            $past(state_q) == ST_FINISH))
    else $error("result produced from a non-finishing state");

endmodule
